// ===== rtl/chs_lba_pkg.sv =====
// Shared types, constants and step functions for the CHS / block address converter.
// Used by chs_lba_div and chs_lba_address_converter; depends on nothing else.
package chs_lba_pkg;

    localparam int BLOCK_ADDRESS_BITS = 32;
    localparam logic [31:0] ADDR_MASK = (BLOCK_ADDRESS_BITS >= 32) ? 32'hFFFF_FFFF :
        32'((64'd1 << BLOCK_ADDRESS_BITS) - 64'd1);

    // first divider produces one quotient bit per stage over the whole input word,
    // the second one splits the remainder into an 8-bit head
    localparam int Q_BITS = 32;
    localparam int H_BITS = 8;
    localparam int N_STEPS = Q_BITS + H_BITS;

    localparam logic OP_CHS_TO_LBA = 1'b0;
    localparam logic OP_LBA_TO_CHS = 1'b1;

    localparam logic REG_HEADS   = 1'b0;
    localparam logic REG_SECTORS = 1'b1;

    localparam logic [7:0] HEADS_RESET   = 8'd16;
    localparam logic [7:0] SECTORS_RESET = 8'd63;

    typedef struct packed {
        logic        op;
        logic        err;
        logic [31:0] blk;
        logic [31:0] dvd;      // dividend bits not yet shifted in
        logic [15:0] rem;      // partial remainder, always below per_cyl
        logic [31:0] quo;
        logic [15:0] per_cyl;
        logic [7:0]  secs;
        logic [15:0] cyl;
        logic [7:0]  rem2;     // partial remainder of head split, below secs
        logic [7:0]  lo;       // low remainder bits not yet shifted in
        logic [7:0]  hq;
    } div_stage_t;

    function automatic div_stage_t cyl_step(div_stage_t s);
        div_stage_t n;
        logic [16:0] trial;
        n = s;
        trial = {s.rem, s.dvd[31]};
        n.dvd = {s.dvd[30:0], 1'b0};
        if (trial >= {1'b0, s.per_cyl})
        begin
            n.rem = 16'(trial - {1'b0, s.per_cyl});
            n.quo = {s.quo[30:0], 1'b1};
        end
        else
        begin
            n.rem = trial[15:0];
            n.quo = {s.quo[30:0], 1'b0};
        end
        return n;
    endfunction

    // saturate the cylinder and load the head split; rem < heads*secs so rem[15:8] < secs
    function automatic div_stage_t head_prep(div_stage_t s);
        div_stage_t n;
        logic ovf;
        n = s;
        ovf = |s.quo[31:16];
        n.cyl = ovf ? 16'hFFFF : s.quo[15:0];
        if (s.op == OP_LBA_TO_CHS && ovf)
        begin
            n.err = 1'b1;
        end
        n.rem2 = s.rem[15:8];
        n.lo   = s.rem[7:0];
        n.hq   = '0;
        return n;
    endfunction

    function automatic div_stage_t head_step(div_stage_t s);
        div_stage_t n;
        logic [8:0] trial;
        n = s;
        trial = {s.rem2, s.lo[7]};
        n.lo = {s.lo[6:0], 1'b0};
        if (trial >= {1'b0, s.secs})
        begin
            n.rem2 = 8'(trial - {1'b0, s.secs});
            n.hq   = {s.hq[6:0], 1'b1};
        end
        else
        begin
            n.rem2 = trial[7:0];
            n.hq   = {s.hq[6:0], 1'b0};
        end
        return n;
    endfunction

endpackage

// ===== rtl/chs_lba_div.sv =====
// Pipelined restoring divider: block / (heads*sectors), then remainder / sectors.
// One quotient bit per stage plus an output register; depends on chs_lba_pkg.
module chs_lba_div
    import chs_lba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  div_stage_t  in_stage,
    output logic        out_valid,
    output logic [31:0] block_address,
    output logic [15:0] cylinder,
    output logic [7:0]  head,
    output logic [7:0]  sector,
    output logic        range_error
);

    logic [N_STEPS-1:0] vld_reg;
    div_stage_t         stg_reg [N_STEPS];

    logic        out_valid_reg;
    logic        out_op_reg;
    logic [31:0] out_blk_reg;
    logic [15:0] out_cyl_reg;
    logic [7:0]  out_head_reg;
    logic [7:0]  out_sec_reg;
    logic        out_err_reg;

    for (genvar i = 0; i < N_STEPS; i++)
    begin : g_stage
        div_stage_t prev;
        div_stage_t stage_next;
        logic       prev_vld;

        if (i == 0)
        begin : g_first
            assign prev     = in_stage;
            assign prev_vld = in_valid;
        end
        else
        begin : g_chain
            assign prev     = stg_reg[i-1];
            assign prev_vld = vld_reg[i-1];
        end

        if (i < Q_BITS)
        begin : g_cyl
            assign stage_next = cyl_step(prev);
        end
        else if (i == Q_BITS)
        begin : g_prep
            assign stage_next = head_step(head_prep(prev));
        end
        else
        begin : g_head
            assign stage_next = head_step(prev);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i] <= prev_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stg_reg[i] <= stage_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[N_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_op_reg  <= stg_reg[N_STEPS-1].op;
            out_err_reg <= stg_reg[N_STEPS-1].err;
            if (stg_reg[N_STEPS-1].op == OP_LBA_TO_CHS)
            begin
                out_blk_reg  <= '0;
                out_cyl_reg  <= stg_reg[N_STEPS-1].cyl;
                out_head_reg <= stg_reg[N_STEPS-1].hq;
                out_sec_reg  <= stg_reg[N_STEPS-1].rem2 + 8'd1;
            end
            else
            begin
                out_blk_reg  <= stg_reg[N_STEPS-1].blk;
                out_cyl_reg  <= '0;
                out_head_reg <= '0;
                out_sec_reg  <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign block_address = out_blk_reg;
    assign cylinder      = out_cyl_reg;
    assign head          = out_head_reg;
    assign sector        = out_sec_reg;
    assign range_error   = out_err_reg;

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[Q_BITS-1] && stg_reg[Q_BITS-1].op == OP_LBA_TO_CHS
        |-> stg_reg[Q_BITS-1].rem < stg_reg[Q_BITS-1].per_cyl)
        else $error("cylinder remainder not below heads*sectors");

    a_head_rem_below_secs: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[N_STEPS-1] && stg_reg[N_STEPS-1].op == OP_LBA_TO_CHS
        |-> stg_reg[N_STEPS-1].rem2 < stg_reg[N_STEPS-1].secs)
        else $error("sector remainder not below sectors per track");

    a_sector_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_op_reg == OP_LBA_TO_CHS |-> out_sec_reg != 8'd0)
        else $error("block to CHS item gave sector zero");

    a_chs_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_op_reg == OP_CHS_TO_LBA
        |-> out_cyl_reg == 16'd0 && out_head_reg == 8'd0 && out_sec_reg == 8'd0)
        else $error("CHS to block item has nonzero CHS fields");

    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_op_reg == OP_LBA_TO_CHS && out_cyl_reg != 16'hFFFF
        |-> !out_err_reg)
        else $error("range_error without cylinder saturation");
`endif

endmodule

// ===== rtl/chs_lba_address_converter.sv =====
// Top level of the CHS / block address converter: config registers, multiply front end.
// Depends on chs_lba_pkg and chs_lba_div.
//
//  channel   signals                                               direction
//  --------  ----------------------------------------------------  ---------
//  config    cfg_valid cfg_ready cfg_index cfg_data                in
//  request   in_valid in_ready operation cylinder_in head_in ...   in
//  result    out_valid out_ready block_address_out cylinder_out..  out
//
// One item per cycle while no result waits with out_ready low; each item passes through:
// five front stages (capture, multiply, add, multiply, sum) and 40 divider stages, one
// quotient bit each, plus the output register. Reset clears config to 16 heads / 63 sectors
// and empties the pipeline. The whole pipeline holds only while a result waits and
// out_ready is low; in_ready follows that same condition.
module chs_lba_address_converter
    import chs_lba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [15:0] cylinder_in,
    input  logic [7:0]  head_in,
    input  logic [7:0]  sector_in,
    input  logic [31:0] block_address_in,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] block_address_out,
    output logic [15:0] cylinder_out,
    output logic [7:0]  head_out,
    output logic [7:0]  sector_out,
    output logic        range_error
);

    logic [7:0] heads_reg;
    logic [7:0] secs_reg;
    logic       adv;

    // stage A: capture
    logic        a_valid_reg;
    logic        a_op_reg;
    logic [15:0] a_cyl_reg;
    logic [7:0]  a_head_reg;
    logic [7:0]  a_sec_reg;
    logic [31:0] a_blk_reg;
    logic [7:0]  a_heads_reg;
    logic [7:0]  a_secs_reg;

    // stage B: products
    logic        b_valid_reg;
    logic        b_op_reg;
    logic [23:0] b_ch_reg;
    logic [7:0]  b_head_reg;
    logic [7:0]  b_sec_reg;
    logic [31:0] b_blk_reg;
    logic [15:0] b_per_cyl_reg;
    logic [7:0]  b_secs_reg;

    // stage C: track index
    logic        c_valid_reg;
    logic        c_op_reg;
    logic [23:0] c_trk_reg;
    logic [7:0]  c_sec_reg;
    logic [31:0] c_blk_reg;
    logic [15:0] c_per_cyl_reg;
    logic [7:0]  c_secs_reg;

    // stage D: track start block
    logic        d_valid_reg;
    logic        d_op_reg;
    logic [31:0] d_prod_reg;
    logic [7:0]  d_sec_reg;
    logic [31:0] d_blk_reg;
    logic [15:0] d_per_cyl_reg;
    logic [7:0]  d_secs_reg;

    // stage E: divider entry
    logic        e_valid_reg;
    div_stage_t  e_stage_reg;
    div_stage_t  e_stage_next;
    logic [32:0] blk_sum;

    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heads_reg <= HEADS_RESET;
            secs_reg  <= SECTORS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HEADS:   heads_reg <= cfg_data;
                REG_SECTORS: secs_reg  <= cfg_data;
                default:     heads_reg <= heads_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // a zero geometry register counts as one
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_op_reg    <= operation;
            a_cyl_reg   <= cylinder_in;
            a_head_reg  <= head_in;
            a_sec_reg   <= sector_in;
            a_blk_reg   <= block_address_in & ADDR_MASK;
            a_heads_reg <= (heads_reg == 8'd0) ? 8'd1 : heads_reg;
            a_secs_reg  <= (secs_reg == 8'd0) ? 8'd1 : secs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_op_reg      <= a_op_reg;
            b_ch_reg      <= 24'(a_cyl_reg) * 24'(a_heads_reg);
            b_head_reg    <= a_head_reg;
            b_sec_reg     <= a_sec_reg;
            b_blk_reg     <= a_blk_reg;
            b_per_cyl_reg <= 16'(a_heads_reg) * 16'(a_secs_reg);
            b_secs_reg    <= a_secs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_op_reg      <= b_op_reg;
            c_trk_reg     <= b_ch_reg + 24'(b_head_reg);
            c_sec_reg     <= b_sec_reg;
            c_blk_reg     <= b_blk_reg;
            c_per_cyl_reg <= b_per_cyl_reg;
            c_secs_reg    <= b_secs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_op_reg      <= c_op_reg;
            d_prod_reg    <= 32'(c_trk_reg) * 32'(c_secs_reg);
            d_sec_reg     <= c_sec_reg;
            d_blk_reg     <= c_blk_reg;
            d_per_cyl_reg <= c_per_cyl_reg;
            d_secs_reg    <= c_secs_reg;
        end
    end

    assign blk_sum = 33'(d_prod_reg) + 33'(d_sec_reg) - 33'd1;

    always_comb
    begin
        e_stage_next         = '0;
        e_stage_next.op      = d_op_reg;
        e_stage_next.dvd     = d_blk_reg;
        e_stage_next.per_cyl = d_per_cyl_reg;
        e_stage_next.secs    = d_secs_reg;
        if (d_op_reg == OP_CHS_TO_LBA)
        begin
            if (d_sec_reg == 8'd0)
            begin
                e_stage_next.err = 1'b1;
            end
            else
            begin
                e_stage_next.blk = blk_sum[31:0] & ADDR_MASK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_stage_reg <= e_stage_next;
        end
    end

    chs_lba_div u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (e_valid_reg),
        .in_stage      (e_stage_reg),
        .out_valid     (out_valid),
        .block_address (block_address_out),
        .cylinder      (cylinder_out),
        .head          (head_out),
        .sector        (sector_out),
        .range_error   (range_error)
    );

endmodule

// ===== tb/tb_chs_lba_address_converter.sv =====
// Self-checking testbench for chs_lba_address_converter: CHS <-> block address conversion
// under several disk geometries, with random stalls on both channels and a full-pipe stall.
// Depends on chs_lba_pkg and the chs_lba_address_converter RTL.
module tb_chs_lba_address_converter
    import chs_lba_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        op;
        logic [15:0] cyl;
        logic [7:0]  head;
        logic [7:0]  sector;
        logic [31:0] blk;
    } chs_request_t;

    typedef struct packed {
        logic [31:0] blk;
        logic [15:0] cyl;
        logic [7:0]  head;
        logic [7:0]  sector;
        logic        err;
    } chs_result_t;

    class addr_scoreboard;
        logic [7:0]  heads_cfg = HEADS_RESET;
        logic [7:0]  secs_cfg = SECTORS_RESET;
        chs_result_t pending_addrs[$];
        int          errors = 0;

        // a zero geometry register acts as one
        function logic [63:0] heads_eff();
            return (heads_cfg == 8'd0) ? 64'd1 : 64'(heads_cfg);
        endfunction

        function logic [63:0] secs_eff();
            return (secs_cfg == 8'd0) ? 64'd1 : 64'(secs_cfg);
        endfunction

        function void set_reg(logic idx, logic [7:0] value);
            if (idx == REG_HEADS)
            begin
                heads_cfg = value;
            end
            else if (idx == REG_SECTORS)
            begin
                secs_cfg = value;
            end
        endfunction

        function chs_result_t convert_address(chs_request_t rq);
            chs_result_t r;
            logic [63:0] hds;
            logic [63:0] sps;
            logic [63:0] per_cyl;
            logic [63:0] lba;
            logic [63:0] quo;
            logic [63:0] rmd;
            r = '0;
            hds = heads_eff();
            sps = secs_eff();
            if (rq.op == OP_CHS_TO_LBA)
            begin
                if (rq.sector == 8'd0)
                begin
                    r.err = 1'b1;
                end
                else
                begin
                    lba = (64'(rq.cyl) * hds + 64'(rq.head)) * sps + 64'(rq.sector) - 64'd1;
                    r.blk = lba[31:0] & ADDR_MASK;
                end
            end
            else
            begin
                lba = 64'(rq.blk & ADDR_MASK);
                per_cyl = hds * sps;
                quo = lba / per_cyl;
                rmd = lba % per_cyl;
                if (quo > 64'hFFFF)
                begin
                    quo = 64'hFFFF;
                    r.err = 1'b1;
                end
                r.cyl = quo[15:0];
                r.head = 8'(rmd / sps);
                r.sector = 8'(rmd % sps + 64'd1);
            end
            return r;
        endfunction

        function void note_request(chs_request_t rq);
            pending_addrs.push_back(convert_address(rq));
        endfunction

        function int pending();
            return pending_addrs.size();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(chs_result_t got);
            chs_result_t want;
            if (pending_addrs.size() == 0)
            begin
                report("result with no item pending", got.blk, 32'd0);
            end
            else
            begin
                want = pending_addrs.pop_front();
                if (got.blk !== want.blk)
                    report("block_address_out", got.blk, want.blk);
                if (got.cyl !== want.cyl)
                    report("cylinder_out", 32'(got.cyl), 32'(want.cyl));
                if (got.head !== want.head)
                    report("head_out", 32'(got.head), 32'(want.head));
                if (got.sector !== want.sector)
                    report("sector_out", 32'(got.sector), 32'(want.sector));
                if (got.err !== want.err)
                    report("range_error", 32'(got.err), 32'(want.err));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        operation;
    logic [15:0] cylinder_in;
    logic [7:0]  head_in;
    logic [7:0]  sector_in;
    logic [31:0] block_address_in;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] block_address_out;
    logic [15:0] cylinder_out;
    logic [7:0]  head_out;
    logic [7:0]  sector_out;
    logic        range_error;

    addr_scoreboard sb = new();
    bit quiet = 1'b0;
    bit long_hold = 1'b0;

    chs_lba_address_converter dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .operation         (operation),
        .cylinder_in       (cylinder_in),
        .head_in           (head_in),
        .sector_in         (sector_in),
        .block_address_in  (block_address_in),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .block_address_out (block_address_out),
        .cylinder_out      (cylinder_out),
        .head_out          (head_out),
        .sector_out        (sector_out),
        .range_error       (range_error)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic logic [31:0] clamp32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic chs_request_t random_request(logic [63:0] heads, logic [63:0] secs);
        chs_request_t rq;
        logic [63:0]  ovf_at;
        int unsigned  pick;
        rq.op = 1'($urandom_range(0, 1));
        rq.cyl = 16'($urandom);
        rq.head = 8'($urandom);
        rq.sector = 8'($urandom);
        rq.blk = $urandom;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            rq.cyl = 16'hFFFF;
        else if (pick == 1)
            rq.cyl = 16'd0;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            rq.head = 8'($urandom_range(0, 32'(heads) - 1));
        else if (pick == 5)
            rq.head = 8'hFF;
        else if (pick == 6)
            rq.head = 8'd0;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            rq.sector = 8'd0;
        else if (pick < 7)
            rq.sector = 8'($urandom_range(1, 32'(secs)));
        else if (pick == 7)
            rq.sector = 8'hFF;
        // most addresses land below the point where the cylinder saturates
        ovf_at = heads * secs * 64'd65536;
        pick = $urandom_range(0, 7);
        if (pick < 4)
            rq.blk = $urandom_range(0, clamp32(ovf_at - 64'd1));
        else if (pick == 4)
            rq.blk = clamp32(ovf_at - 64'd2 + 64'($urandom_range(0, 3)));
        else if (pick == 5)
            rq.blk = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
        return rq;
    endfunction

    task automatic send_request(chs_request_t rq);
        @(negedge clk);
        in_valid = 1'b1;
        operation = rq.op;
        cylinder_in = rq.cyl;
        head_in = rq.head;
        sector_in = rq.sector;
        block_address_in = rq.blk;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(rq);
    endtask

    task automatic idle_sender(int unsigned cycles);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // stop offering before waiting, so the last item is not taken again
    task automatic wait_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic run_directed();
        chs_request_t rq;
        logic [63:0]  ovf_at;
        ovf_at = sb.heads_eff() * sb.secs_eff() * 64'd65536;
        rq = '0;
        rq.op = OP_CHS_TO_LBA;
        rq.sector = 8'd1;
        send_request(rq);
        rq.cyl = 16'hFFFF;
        rq.head = 8'hFF;
        rq.sector = 8'hFF;
        rq.blk = 32'hFFFF_FFFF;
        send_request(rq);
        rq.sector = 8'd0;
        send_request(rq);
        // head past the geometry still goes through the formula
        rq.cyl = 16'd1;
        rq.sector = 8'(sb.secs_eff());
        send_request(rq);
        rq = '0;
        rq.op = OP_LBA_TO_CHS;
        send_request(rq);
        rq.blk = 32'hFFFF_FFFF;
        rq.cyl = 16'hFFFF;
        rq.head = 8'hFF;
        rq.sector = 8'hFF;
        send_request(rq);
        // last address with an exact cylinder, then the first one that saturates
        rq.blk = clamp32(ovf_at - 64'd1);
        send_request(rq);
        rq.blk = clamp32(ovf_at);
        send_request(rq);
    endtask

    // result side: short random stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ready = 1'b0;
                repeat (300)
                    @(negedge clk);
                long_hold = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 5))
                    @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result({block_address_out, cylinder_out, head_out, sector_out,
                             range_error});
        end
    end

    initial
    begin
        logic [7:0]  geo_heads[8];
        logic [7:0]  geo_secs[8];
        int unsigned count;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_HEADS;
        cfg_data = 8'd0;
        in_valid = 1'b0;
        operation = OP_CHS_TO_LBA;
        cylinder_in = 16'd0;
        head_in = 8'd0;
        sector_in = 8'd0;
        block_address_in = 32'd0;
        geo_heads = '{HEADS_RESET, 8'd255, 8'd0, 8'd1, 8'd255, 8'd0, 8'd0, 8'd1};
        geo_secs = '{SECTORS_RESET, 8'd255, 8'd0, 8'd255, 8'd1, 8'd0, 8'd0, 8'd1};
        geo_heads[5] = 8'($urandom_range(1, 255));
        geo_secs[5] = 8'($urandom_range(1, 255));
        geo_heads[6] = 8'($urandom_range(1, 255));
        geo_secs[6] = 8'($urandom_range(1, 255));
        repeat (12)
            @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < 8; p++)
        begin
            // phase 0 runs on the reset geometry
            if (p > 0)
            begin
                wait_drain();
                write_reg(REG_HEADS, geo_heads[p]);
                write_reg(REG_SECTORS, geo_secs[p]);
            end
            if (p < 3)
                run_directed();
            if (p == 7)
                quiet = 1'b1;
            count = (p < 2) ? 140 : 130;
            for (int i = 0; i < count; i++)
            begin
                if (p == 1 && i == 30)
                    long_hold = 1'b1;
                if (p == 3 && i == 60)
                    wait_drain();
                send_request(random_request(sb.heads_eff(), sb.secs_eff()));
                if (!quiet && $urandom_range(0, 4) == 0)
                    idle_sender($urandom_range(1, 5));
            end
        end
        @(negedge clk);
        in_valid = 1'b0;

        wait_drain();
        repeat (60)
            @(negedge clk);
        if (sb.pending() != 0)
            sb.report("items left without a result", 32'(sb.pending()), 32'd0);
        if (sb.errors == 0)
            $display("tb_chs_lba_address_converter OK");
        else
            $display("tb_chs_lba_address_converter NOT OK");
        $finish;
    end

    initial
    begin
        #400_000;
        $display("tb_chs_lba_address_converter NOT OK");
        $finish;
    end

endmodule
